>>> hdl/tfss_pkg.sv
// Shared types and constants for the top-five score selector.
`default_nettype none
package tfss_pkg;

   localparam int TAG_W   = 16;
   localparam int SCORE_W = 14;
   localparam int RANK_W  = 3;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [SCORE_W-1:0] score;
      logic               last;
   } record_type;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [SCORE_W-1:0] score;
   } entry_type;

   typedef struct packed {
      logic       valid;
      record_type rec;
   } queue_out_type;

   typedef enum logic [0:0] {
      ST_COLLECT,
      ST_EMIT
   } engine_state_type;

endpackage
`default_nettype wire

>>> hdl/top_five_score_select.sv
// Top level of the top-five score selector: command front, record queue, ranking engine.
// Accepts one record a cycle while the queue has room; busy rises when the queue is full.
// The ranking engine inserts one record a cycle into its sorted list while not emitting.
// A record marked last that finds the queue empty passes the queue, engine state and
// result registers before its first result strobe, then one result a cycle,
// n results for n held entries (n at most TOP_COUNT). Results cannot be stalled.
// Synchronous reset empties the queue and the list and drops any pending results.
`default_nettype none
module top_five_score_select #(
   parameter int TOP_COUNT   = 5,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [tfss_pkg::TAG_W-1:0]    req_student_tag,
   input  wire logic [tfss_pkg::SCORE_W-1:0]  req_score,
   input  wire logic                          req_last_student,
   output logic                               rsp_valid,
   output logic [tfss_pkg::RANK_W-1:0]        rsp_rank,
   output logic [tfss_pkg::TAG_W-1:0]         rsp_ranked_tag,
   output logic [tfss_pkg::SCORE_W-1:0]       rsp_ranked_score,
   output logic                               rsp_last_of_run
);
   import tfss_pkg::*;

   record_type    req_rec;
   queue_out_type head;
   logic          queue_full;
   logic          accept;
   logic          pop;

   assign busy         = queue_full;
   assign accept       = start && !queue_full;
   assign req_rec.tag  = req_student_tag;
   assign req_rec.score = req_score;
   assign req_rec.last = req_last_student;

   tfss_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_rec (req_rec),
      .full     (queue_full),
      .pop      (pop),
      .head     (head)
   );

   tfss_rank #(
      .TOP_COUNT (TOP_COUNT)
   ) u_rank (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_rank         (rsp_rank),
      .rsp_ranked_tag   (rsp_ranked_tag),
      .rsp_ranked_score (rsp_ranked_score),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_run |=> !rsp_valid)
      else $error("result beat follows the final beat of a run");

   a_rank_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |=>
         rsp_valid && (rsp_rank == RANK_W'($past(rsp_rank) + 3'd1)))
      else $error("run broken or rank did not advance by one");

   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |=> !rsp_valid || (rsp_rank == 3'd1))
      else $error("run does not open at rank one");

endmodule
`default_nettype wire

>>> hdl/tfss_queue.sv
// Record queue between the accepting front and the ranking engine.
`default_nettype none
module tfss_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire tfss_pkg::record_type   push_rec,
   output logic                        full,
   input  wire logic                   pop,
   output tfss_pkg::queue_out_type     head
);
   import tfss_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   record_type       mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.rec   = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule
`default_nettype wire

>>> hdl/tfss_rank.sv
// Ranking engine: sorted insert of each record and shift-out of the list per batch.
`default_nettype none
module tfss_rank #(
   parameter int TOP_COUNT = 5
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire tfss_pkg::queue_out_type        head,
   output logic                                pop,
   output logic                                rsp_valid,
   output logic [tfss_pkg::RANK_W-1:0]         rsp_rank,
   output logic [tfss_pkg::TAG_W-1:0]          rsp_ranked_tag,
   output logic [tfss_pkg::SCORE_W-1:0]        rsp_ranked_score,
   output logic                                rsp_last_of_run
);
   import tfss_pkg::*;

   localparam int CNT_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
   localparam int EXT_W = CNT_W + RANK_W + 1;

   engine_state_type     state_ff, state_in;
   entry_type            entry_ff [TOP_COUNT];
   entry_type            entry_in [TOP_COUNT];
   entry_type            new_entry;
   logic [TOP_COUNT-1:0] valid_ff, valid_in;
   logic [TOP_COUNT-1:0] valid_shift;
   logic [TOP_COUNT-1:0] ge;
   logic [CNT_W-1:0]     rank_ff, rank_in;
   logic [EXT_W-1:0]     rank_ext;
   logic                 emit;
   logic                 last_emit;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RANK_W-1:0]    rsp_rank_ff, rsp_rank_in;
   logic [TAG_W-1:0]     rsp_tag_ff, rsp_tag_in;
   logic [SCORE_W-1:0]   rsp_score_ff, rsp_score_in;
   logic                 rsp_last_ff, rsp_last_in;

   assign new_entry.tag   = head.rec.tag;
   assign new_entry.score = head.rec.score;
   assign valid_shift     = valid_ff >> 1;
   assign last_emit       = emit && !valid_shift[0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (pop && head.rec.last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (last_emit) begin
               state_in = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   // state outputs
   always_comb begin
      pop  = 1'b0;
      emit = 1'b0;
      case (state_ff)
         ST_COLLECT: begin
            pop = head.valid;
         end
         ST_EMIT: begin
            emit = 1'b1;
         end
         default: begin
            pop  = 1'b0;
            emit = 1'b0;
         end
      endcase
   end

   // compare against every held entry; ties keep the earlier arrival ahead
   always_comb begin
      for (int i = 0; i < TOP_COUNT; i++) begin
         ge[i] = valid_ff[i] && (entry_ff[i].score >= head.rec.score);
      end
   end

   always_comb begin
      for (int i = 0; i < TOP_COUNT; i++) begin
         entry_in[i] = entry_ff[i];
      end
      valid_in     = valid_ff;
      rank_in      = rank_ff;
      rank_ext     = EXT_W'(rank_ff) + 1'b1;
      rsp_valid_in = 1'b0;
      rsp_rank_in  = rank_ext[RANK_W-1:0];
      rsp_tag_in   = entry_ff[0].tag;
      rsp_score_in = entry_ff[0].score;
      rsp_last_in  = !valid_shift[0];
      if (pop) begin
         if (!ge[0]) begin
            entry_in[0] = new_entry;
         end
         for (int i = 1; i < TOP_COUNT; i++) begin
            if (!ge[i]) begin
               entry_in[i] = ge[i-1] ? new_entry : entry_ff[i-1];
            end
         end
         valid_in = (valid_ff << 1) | TOP_COUNT'(1);
      end else if (emit) begin
         // advance the list one place toward the head
         for (int i = 0; i < TOP_COUNT - 1; i++) begin
            entry_in[i] = entry_ff[i+1];
         end
         valid_in     = valid_shift;
         rsp_valid_in = 1'b1;
         rank_in      = last_emit ? '0 : rank_ext[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         valid_ff     <= '0;
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rank_ff      <= rank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TOP_COUNT; i++) begin
         entry_ff[i] <= entry_in[i];
      end
      rsp_rank_ff  <= rsp_rank_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_score_ff <= rsp_score_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rank         = rsp_rank_ff;
   assign rsp_ranked_tag   = rsp_tag_ff;
   assign rsp_ranked_score = rsp_score_ff;
   assign rsp_last_of_run  = rsp_last_ff;

endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking bench for top_five_score_select: directed table, then random batches.
`default_nettype none
module tb;
   import tfss_pkg::*;

   localparam int TOP_COUNT    = 5;
   localparam int RANDOM_ITEMS = 132;
   localparam int CYCLE_LIMIT  = 40000;
   localparam int PLAN_ROWS    = 23;

   typedef struct packed {
      logic [RANK_W-1:0]  rank;
      logic [TAG_W-1:0]   tag;
      logic [SCORE_W-1:0] score;
      logic               fin;
   } ranked_row_type;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [SCORE_W-1:0] score;
      logic               fin;
      logic               typed;
      logic [TAG_W-1:0]   exp_tag;
      logic [SCORE_W-1:0] exp_score;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [TAG_W-1:0]   req_student_tag = '0;
   logic [SCORE_W-1:0] req_score = '0;
   logic               req_last_student = 1'b0;
   logic               rsp_valid;
   logic [RANK_W-1:0]  rsp_rank;
   logic [TAG_W-1:0]   rsp_ranked_tag;
   logic [SCORE_W-1:0] rsp_ranked_score;
   logic               rsp_last_of_run;

   // sideband for the beat on the request ports
   logic               beat_typed = 1'b0;
   logic [TAG_W-1:0]   beat_exp_tag = '0;
   logic [SCORE_W-1:0] beat_exp_score = '0;

   logic [TAG_W-1:0]   held_tag [TOP_COUNT];
   logic [SCORE_W-1:0] held_score [TOP_COUNT];
   int                 held_count = 0;
   ranked_row_type     pending_ranks [$];

   int mismatches = 0;
   int records_ranked = 0;
   int batches_closed = 0;
   int results_checked = 0;
   int cycle_count = 0;

   stim_row_type plan [PLAN_ROWS] = '{
      '{16'hFFFF, 14'h3FFF, 1'b1, 1'b1, 16'hFFFF, 14'h3FFF},
      '{16'h0000, 14'd0,    1'b1, 1'b1, 16'h0000, 14'd0},
      '{16'h1234, 14'd10000, 1'b1, 1'b1, 16'h1234, 14'd10000},
      '{16'd1, 14'd5000, 1'b0, 1'b0, 16'd0, 14'd0},
      '{16'd2, 14'd5000, 1'b0, 1'b0, 16'd0, 14'd0},
      '{16'd3, 14'd9000, 1'b0, 1'b0, 16'd0, 14'd0},
      '{16'd4, 14'd100,  1'b0, 1'b0, 16'd0, 14'd0},
      '{16'd5, 14'd5000, 1'b0, 1'b0, 16'd0, 14'd0},
      '{16'd6, 14'd7000, 1'b0, 1'b0, 16'd0, 14'd0},
      '{16'd7, 14'd50,   1'b0, 1'b0, 16'd0, 14'd0},
      '{16'd8, 14'd0,    1'b1, 1'b0, 16'd0, 14'd0},
      '{16'hAAAA, 14'd200, 1'b0, 1'b0, 16'd0, 14'd0},
      '{16'h5555, 14'd300, 1'b1, 1'b0, 16'd0, 14'd0},
      '{16'h0101, 14'd4242, 1'b0, 1'b0, 16'd0, 14'd0},
      '{16'h0202, 14'd4242, 1'b0, 1'b0, 16'd0, 14'd0},
      '{16'h0303, 14'd4242, 1'b0, 1'b0, 16'd0, 14'd0},
      '{16'h0404, 14'd4242, 1'b1, 1'b0, 16'd0, 14'd0},
      '{16'h0010, 14'd1,     1'b0, 1'b0, 16'd0, 14'd0},
      '{16'h0020, 14'd2,     1'b0, 1'b0, 16'd0, 14'd0},
      '{16'h0030, 14'd3,     1'b0, 1'b0, 16'd0, 14'd0},
      '{16'h0040, 14'd16383, 1'b0, 1'b0, 16'd0, 14'd0},
      '{16'h0050, 14'd10001, 1'b0, 1'b0, 16'd0, 14'd0},
      '{16'hFFFE, 14'd8191,  1'b1, 1'b0, 16'd0, 14'd0}
   };

   top_five_score_select dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_student_tag  (req_student_tag),
      .req_score        (req_score),
      .req_last_student (req_last_student),
      .rsp_valid        (rsp_valid),
      .rsp_rank         (rsp_rank),
      .rsp_ranked_tag   (rsp_ranked_tag),
      .rsp_ranked_score (rsp_ranked_score),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      mismatches++;
   endtask

   task automatic rank_record(input logic [TAG_W-1:0] tag, input logic [SCORE_W-1:0] score,
                              input logic fin);
      int pos;
      int i;
      ranked_row_type r;
      pos = 0;
      while (pos < held_count && held_score[pos] >= score) pos++;
      if (pos < TOP_COUNT) begin
         for (i = (held_count < TOP_COUNT) ? held_count : TOP_COUNT - 1; i > pos; i--) begin
            held_tag[i]   = held_tag[i-1];
            held_score[i] = held_score[i-1];
         end
         held_tag[pos]   = tag;
         held_score[pos] = score;
         if (held_count < TOP_COUNT) held_count++;
      end
      if (fin) begin
         for (i = 0; i < held_count; i++) begin
            r.rank  = RANK_W'(i + 1);
            r.tag   = held_tag[i];
            r.score = held_score[i];
            r.fin   = (i + 1 == held_count);
            pending_ranks.push_back(r);
         end
         held_count = 0;
      end
   endtask

   always @(posedge clock) begin
      ranked_row_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout with %0d results outstanding", pending_ranks.size());
         $display("Some tests failed");
         $finish;
      end
      if (!reset && start && !busy) begin
         records_ranked++;
         if (req_last_student) batches_closed++;
         if (beat_typed) begin
            want.rank  = RANK_W'(1);
            want.tag   = beat_exp_tag;
            want.score = beat_exp_score;
            want.fin   = 1'b1;
            pending_ranks.push_back(want);
            held_count = 0;
         end else begin
            rank_record(req_student_tag, req_score, req_last_student);
         end
      end
      if (!reset && rsp_valid) begin
         results_checked++;
         if (pending_ranks.size() == 0) begin
            report_mismatch("unexpected result, rank", rsp_rank, 0);
         end else begin
            want = pending_ranks.pop_front();
            if (rsp_rank !== want.rank) report_mismatch("rank", rsp_rank, want.rank);
            if (rsp_ranked_tag !== want.tag)
               report_mismatch("ranked_tag", rsp_ranked_tag, want.tag);
            if (rsp_ranked_score !== want.score)
               report_mismatch("ranked_score", rsp_ranked_score, want.score);
            if (rsp_last_of_run !== want.fin)
               report_mismatch("last_of_run", rsp_last_of_run, want.fin);
         end
      end
   end

   task automatic send_record(input stim_row_type row, input bit idle_on);
      if (idle_on) begin
         while ($urandom_range(0, 99) < 6) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start            <= 1'b1;
      req_student_tag  <= row.tag;
      req_score        <= row.score;
      req_last_student <= row.fin;
      beat_typed       <= row.typed;
      beat_exp_tag     <= row.exp_tag;
      beat_exp_score   <= row.exp_score;
      // hold until the beat is taken
      do @(posedge clock); while (busy);
   endtask

   initial begin
      stim_row_type row;
      int sent;
      int batch_len;
      int tie_level;
      int i;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < PLAN_ROWS; i++) send_record(plan[i], 1'b1);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         batch_len = $urandom_range(1, 12);
         tie_level = $urandom_range(0, 3);
         for (i = 0; i < batch_len; i++) begin
            row.tag = TAG_W'($urandom_range(0, 65535));
            if (tie_level == 0) row.score = SCORE_W'($urandom_range(0, 4) * 2500);
            else if ($urandom_range(0, 9) == 0) row.score = SCORE_W'($urandom_range(0, 16383));
            else row.score = SCORE_W'($urandom_range(0, 10000));
            row.fin       = (i == batch_len - 1);
            row.typed     = 1'b0;
            row.exp_tag   = '0;
            row.exp_score = '0;
            // no idling for a long stretch in the middle
            send_record(row, !(sent >= 40 && sent < 100));
            sent++;
         end
      end
      start <= 1'b0;

      while (pending_ranks.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Ranked %0d records in %0d batches, including ties, drops and short batches",
               records_ranked, batches_closed);
      $display("Checked %0d ranked results, %0d mismatches", results_checked, mismatches);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
hdl/tfss_pkg.sv
hdl/tfss_queue.sv
hdl/tfss_rank.sv
hdl/top_five_score_select.sv
tb/tb.sv
